[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the odometry kinematics RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define OBK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OBK_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define OBK_ASSERT(lbl, prop, msg)
`define OBK_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[rtl/core/obk_pkg.sv]
// ----------------------------------------------------------------------------
// obk_pkg
// Types, constants and fixed-point helpers of the omni base odometry block.
// ----------------------------------------------------------------------------
package obk_pkg;

    localparam int VEL_W        = 16;
    localparam int POS_W        = 32;
    localparam int HDG_W        = 16;
    localparam int PER_W        = 16;
    localparam int OFS_W        = 15;
    localparam int MUL_A_W      = 20;
    localparam int MUL_B_W      = 26;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int ACC_W        = 48;
    localparam int TRIG_W       = 18;
    localparam int ZANG_W       = 17;
    localparam int ATAN_W       = 14;
    localparam int CORDIC_STEPS = 14;
    localparam int CSTEP_W      = $clog2(CORDIC_STEPS);
    localparam int DIVN_W       = 35;
    localparam int DIVD_W       = 21;
    localparam int DSTEP_W      = $clog2(DIVN_W);
    localparam int HACC_W       = 58;

    localparam int BODY_GAIN  = 37005;
    localparam int CNT_GAIN   = 104665;
    localparam int COS45_GAIN = 23170;
    localparam int HEAD_GAIN  = 21361415;
    localparam int INV_GAIN   = 19898;

    localparam logic [PER_W-1:0] PERIOD_RESET = PER_W'(655);
    localparam logic [OFS_W-1:0] OFFSET_RESET = OFS_W'(819);

    typedef logic [0:0] obk_cfg_idx_t;
    localparam obk_cfg_idx_t CFG_SAMPLE_PERIOD = 1'b0;
    localparam obk_cfg_idx_t CFG_WHEEL_OFFSET  = 1'b1;

    typedef struct packed {
        logic signed [VEL_W-1:0] wheel_speed_one;
        logic signed [VEL_W-1:0] wheel_speed_two;
        logic signed [VEL_W-1:0] wheel_speed_three;
        logic signed [VEL_W-1:0] wheel_speed_four;
        logic                    hold_heading;
        logic signed [VEL_W-1:0] cmd_vel_x;
        logic signed [VEL_W-1:0] cmd_vel_y;
        logic signed [VEL_W-1:0] cmd_turn_rate;
    } obk_tick_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic        [HDG_W-1:0] heading;
        logic signed [VEL_W-1:0] wheel_set_one;
        logic signed [VEL_W-1:0] wheel_set_two;
        logic signed [VEL_W-1:0] wheel_set_three;
        logic signed [VEL_W-1:0] wheel_set_four;
    } obk_result_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } obk_trig_t;

    function automatic logic [ATAN_W-1:0] atan_entry(input logic [CSTEP_W-1:0] i);
        logic [ATAN_W-1:0] r;
        unique case (i)
            4'd0:    r = ATAN_W'(8192);
            4'd1:    r = ATAN_W'(4836);
            4'd2:    r = ATAN_W'(2555);
            4'd3:    r = ATAN_W'(1297);
            4'd4:    r = ATAN_W'(651);
            4'd5:    r = ATAN_W'(326);
            4'd6:    r = ATAN_W'(163);
            4'd7:    r = ATAN_W'(81);
            4'd8:    r = ATAN_W'(41);
            4'd9:    r = ATAN_W'(20);
            4'd10:   r = ATAN_W'(10);
            4'd11:   r = ATAN_W'(5);
            4'd12:   r = ATAN_W'(3);
            4'd13:   r = ATAN_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    // round half away from zero, then shift right
    function automatic logic signed [ACC_W-1:0] rnd_shift(
        input logic signed [ACC_W-1:0] v,
        input int                      s
    );
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        r   = (mag + (ACC_W'(1) << (s - 1))) >> s;
        return v[ACC_W-1] ? $signed(-r) : $signed(r);
    endfunction

    function automatic logic signed [VEL_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [VEL_W-1:0] r;
        if (v > ACC_W'(32767))
            r = 16'sh7FFF;
        else if (v < -ACC_W'(32768))
            r = 16'sh8000;
        else
            r = v[VEL_W-1:0];
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > ACC_W'(64'sh7FFFFFFF))
            r = 32'sh7FFFFFFF;
        else if (v < -ACC_W'(64'sh80000000))
            r = 32'sh80000000;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

[rtl/core/obk_cordic.sv]
// ----------------------------------------------------------------------------
// obk_cordic
// Iterative CORDIC: cosine and sine of a binary angle, one step per cycle.
// ----------------------------------------------------------------------------
module obk_cordic (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [obk_pkg::HDG_W-1:0]   angle,
    output logic                        busy,
    output obk_pkg::obk_trig_t          trig
);

    logic                                busy_reg;
    logic [obk_pkg::CSTEP_W-1:0]         cnt_reg;
    logic signed [obk_pkg::TRIG_W-1:0]   x_reg;
    logic signed [obk_pkg::TRIG_W-1:0]   y_reg;
    logic signed [obk_pkg::ZANG_W-1:0]   z_reg;
    logic [1:0]                          q_reg;
    logic [obk_pkg::HDG_W-1:0]           qsum;
    logic [obk_pkg::HDG_W-1:0]           zfold;
    logic signed [obk_pkg::TRIG_W-1:0]   xs;
    logic signed [obk_pkg::TRIG_W-1:0]   ys;
    logic signed [obk_pkg::ZANG_W-1:0]   atan_v;

    assign qsum   = angle + obk_pkg::HDG_W'(8192);
    assign zfold  = angle - {qsum[15:14], 14'd0};
    assign xs     = x_reg >>> cnt_reg;
    assign ys     = y_reg >>> cnt_reg;
    assign atan_v = $signed({3'b000, obk_pkg::atan_entry(cnt_reg)});
    assign busy   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == obk_pkg::CSTEP_W'(obk_pkg::CORDIC_STEPS - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= obk_pkg::TRIG_W'(obk_pkg::INV_GAIN);
            y_reg <= '0;
            z_reg <= obk_pkg::ZANG_W'($signed(zfold));
            q_reg <= qsum[15:14];
        end
        else if (busy_reg)
        begin
            if (!z_reg[obk_pkg::ZANG_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_v;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_v;
            end
        end
    end

    always_comb
    begin
        unique case (q_reg)
            2'd0:
            begin
                trig.cos_v = x_reg;
                trig.sin_v = y_reg;
            end
            2'd1:
            begin
                trig.cos_v = -y_reg;
                trig.sin_v = x_reg;
            end
            2'd2:
            begin
                trig.cos_v = -x_reg;
                trig.sin_v = -y_reg;
            end
            default:
            begin
                trig.cos_v = y_reg;
                trig.sin_v = -x_reg;
            end
        endcase
    end

endmodule

[rtl/core/obk_divider.sv]
// ----------------------------------------------------------------------------
// obk_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module obk_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [obk_pkg::DIVN_W-1:0]  dividend,
    input  logic [obk_pkg::DIVD_W-1:0]  divisor,
    output logic                        busy,
    output logic [obk_pkg::DIVN_W-1:0]  quotient
);

    logic                              busy_reg;
    logic [obk_pkg::DSTEP_W-1:0]       cnt_reg;
    logic [obk_pkg::DIVN_W-1:0]        quo_reg;
    logic [obk_pkg::DIVD_W-1:0]        rem_reg;
    logic [obk_pkg::DIVD_W-1:0]        dsr_reg;
    logic [obk_pkg::DIVD_W:0]          trial;
    logic                              fits;

    assign trial    = {rem_reg, quo_reg[obk_pkg::DIVN_W-1]};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == obk_pkg::DSTEP_W'(obk_pkg::DIVN_W - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[obk_pkg::DIVN_W-2:0], fits};
            if (fits)
                rem_reg <= obk_pkg::DIVD_W'(trial - {1'b0, dsr_reg});
            else
                rem_reg <= trial[obk_pkg::DIVD_W-1:0];
        end
    end

endmodule

[rtl/core/omni_base_odometry_kinematics.sv]
// ----------------------------------------------------------------------------
// omni_base_odometry_kinematics
// Dead reckoning and wheel set points of a four-wheel 45-degree omni base.
//   tick channel (tick_valid / tick_stall / tick): one transaction per control
//   tick with four wheel speeds, the heading hold flag and the velocity command.
//   result channel (result_valid / result_stall / result): one transaction per
//   tick with position, heading and four wheel set points.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   sample period (index 0) and the wheel offset (index 1); cfg_ready is
//   always high. Write only while no tick is in flight.
//   A tick runs from acceptance to result_valid through a 35-step divider
//   for the yaw rate, two 14-step CORDIC runs and 21 passes through the one
//   shared multiplier. tick_stall is high from acceptance until the result is
//   loaded, so no new tick is accepted while one is in flight.
//   While result_stall holds a result in the output register the next tick can
//   be accepted, but its result waits until the register is taken.
//   Reset clears position, heading and previous velocities, and loads the
//   default sample period and wheel offset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module omni_base_odometry_kinematics (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick_valid,
    output logic                          tick_stall,
    input  obk_pkg::obk_tick_t            tick,
    output logic                          result_valid,
    input  logic                          result_stall,
    output obk_pkg::obk_result_t          result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  obk_pkg::obk_cfg_idx_t         cfg_index,
    input  logic [obk_pkg::PER_W-1:0]     cfg_data
);

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
    localparam logic [ST_W-1:0] S_M0    = 5'd1;
    localparam logic [ST_W-1:0] S_M1    = 5'd2;
    localparam logic [ST_W-1:0] S_M2    = 5'd3;
    localparam logic [ST_W-1:0] S_M3    = 5'd4;
    localparam logic [ST_W-1:0] S_DIV   = 5'd5;
    localparam logic [ST_W-1:0] S_R0    = 5'd6;
    localparam logic [ST_W-1:0] S_R1    = 5'd7;
    localparam logic [ST_W-1:0] S_R2    = 5'd8;
    localparam logic [ST_W-1:0] S_R3    = 5'd9;
    localparam logic [ST_W-1:0] S_R4    = 5'd10;
    localparam logic [ST_W-1:0] S_P0    = 5'd11;
    localparam logic [ST_W-1:0] S_P1    = 5'd12;
    localparam logic [ST_W-1:0] S_H0    = 5'd13;
    localparam logic [ST_W-1:0] S_H1    = 5'd14;
    localparam logic [ST_W-1:0] S_H2    = 5'd15;
    localparam logic [ST_W-1:0] S_COR   = 5'd16;
    localparam logic [ST_W-1:0] S_CWAIT = 5'd17;
    localparam logic [ST_W-1:0] S_I0    = 5'd18;
    localparam logic [ST_W-1:0] S_I1    = 5'd19;
    localparam logic [ST_W-1:0] S_I2    = 5'd20;
    localparam logic [ST_W-1:0] S_I3    = 5'd21;
    localparam logic [ST_W-1:0] S_I4    = 5'd22;
    localparam logic [ST_W-1:0] S_I5    = 5'd23;
    localparam logic [ST_W-1:0] S_K1    = 5'd24;
    localparam logic [ST_W-1:0] S_K2    = 5'd25;
    localparam logic [ST_W-1:0] S_K3    = 5'd26;
    localparam logic [ST_W-1:0] S_K4    = 5'd27;
    localparam logic [ST_W-1:0] S_DONE  = 5'd28;

    localparam int ACC_W  = obk_pkg::ACC_W;
    localparam int VEL_W  = obk_pkg::VEL_W;
    localparam int A_W    = obk_pkg::MUL_A_W;
    localparam int B_W    = obk_pkg::MUL_B_W;
    localparam int P_W    = obk_pkg::PROD_W;
    localparam int H_W    = obk_pkg::HACC_W;
    localparam int SUM_W  = 18;

    logic [ST_W-1:0]                   state_reg;
    logic [ST_W-1:0]                   state_next;

    obk_pkg::obk_tick_t                tick_reg;
    logic [obk_pkg::PER_W-1:0]         period_reg;
    logic [obk_pkg::OFS_W-1:0]         offset_reg;
    logic signed [obk_pkg::POS_W-1:0]  pos_x_reg;
    logic signed [obk_pkg::POS_W-1:0]  pos_y_reg;
    logic [obk_pkg::HDG_W-1:0]         heading_reg;
    logic signed [VEL_W-1:0]           pvx_reg;
    logic signed [VEL_W-1:0]           pvy_reg;
    logic signed [VEL_W-1:0]           pw_reg;
    logic signed [VEL_W-1:0]           bx_reg;
    logic signed [VEL_W-1:0]           by_reg;
    logic signed [VEL_W-1:0]           vx_reg;
    logic signed [VEL_W-1:0]           vy_reg;
    logic signed [VEL_W-1:0]           w_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [P_W-1:0]             prod_reg;
    logic [obk_pkg::POS_W-1:0]         hmag_reg;
    logic                              hneg_reg;
    logic [H_W-1:0]                    hacc_reg;
    logic                              wneg_reg;
    logic signed [A_W-1:0]             bxi_reg;
    logic signed [A_W-1:0]             byi_reg;
    logic signed [A_W-1:0]             td_reg;
    logic signed [VEL_W-1:0]           set_reg [4];
    obk_pkg::obk_result_t              result_reg;
    logic                              result_valid_reg;

    logic signed [A_W-1:0]             mul_a;
    logic signed [B_W-1:0]             mul_b;
    logic signed [SUM_W-1:0]           v1;
    logic signed [SUM_W-1:0]           v2;
    logic signed [SUM_W-1:0]           v3;
    logic signed [SUM_W-1:0]           v4;
    logic signed [SUM_W-1:0]           sum_x;
    logic signed [SUM_W-1:0]           sum_y;
    logic signed [SUM_W-1:0]           sum_w;
    logic signed [ACC_W-1:0]           prod_ext;
    logic signed [ACC_W-1:0]           td_ext;
    logic [P_W-1:0]                    prod_abs;
    logic [obk_pkg::OFS_W-1:0]         dd;
    logic [obk_pkg::DIVN_W-1:0]        div_dividend;
    logic [obk_pkg::DIVD_W-1:0]        div_divisor;
    logic [obk_pkg::DIVN_W-1:0]        div_quotient;
    logic signed [obk_pkg::DIVN_W:0]   w_signed;
    logic                              div_start;
    logic                              div_busy;
    logic                              cor_start;
    logic                              cor_busy;
    obk_pkg::obk_trig_t                trig;
    logic signed [A_W-1:0]             cos_a;
    logic signed [A_W-1:0]             sin_a;
    logic [H_W-1:0]                    hsum;
    logic [obk_pkg::HDG_W-1:0]         dh;
    logic                              tick_acc;
    logic                              result_load;

    assign tick_stall   = (state_reg != S_IDLE);
    assign tick_acc     = tick_valid && !tick_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign result_load  = (state_reg == S_DONE) && (!result_valid_reg || !result_stall);

    assign v1    = SUM_W'(tick_reg.wheel_speed_one);
    assign v2    = SUM_W'(tick_reg.wheel_speed_two);
    assign v3    = SUM_W'(tick_reg.wheel_speed_three);
    assign v4    = SUM_W'(tick_reg.wheel_speed_four);
    assign sum_x = v1 - v2 - v3 + v4;
    assign sum_y = v1 + v2 - v3 - v4;
    assign sum_w = v1 + v2 + v3 + v4;

    assign prod_ext = ACC_W'(prod_reg);
    assign td_ext   = ACC_W'(td_reg);
    assign prod_abs = prod_reg[P_W-1] ? P_W'(-prod_reg) : P_W'(prod_reg);
    assign cos_a    = A_W'(trig.cos_v);
    assign sin_a    = A_W'(trig.sin_v);

    assign dd           = (offset_reg == '0) ? obk_pkg::OFS_W'(1) : offset_reg;
    assign div_divisor  = {dd, 6'd0};
    assign div_dividend = prod_abs[obk_pkg::DIVN_W-1:0]
                        + obk_pkg::DIVN_W'({dd, 5'd0});
    assign div_start    = (state_reg == S_M3);
    assign w_signed     = wneg_reg ? -$signed({1'b0, div_quotient})
                                   : $signed({1'b0, div_quotient});

    assign cor_start = tick_acc || (state_reg == S_COR);

    assign hsum = hacc_reg + H_W'(prod_reg[41:0]) + (H_W'(1) << 39);
    assign dh   = hneg_reg ? -hsum[55:40] : hsum[55:40];

    obk_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .angle (heading_reg),
        .busy  (cor_busy),
        .trig  (trig)
    );

    obk_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_M0:
            begin
                mul_a = A_W'(sum_x);
                mul_b = B_W'(obk_pkg::BODY_GAIN);
            end
            S_M1:
            begin
                mul_a = A_W'(sum_y);
                mul_b = B_W'(obk_pkg::BODY_GAIN);
            end
            S_M2:
            begin
                mul_a = A_W'(sum_w);
                mul_b = B_W'(obk_pkg::CNT_GAIN);
            end
            S_R0:
            begin
                mul_a = cos_a;
                mul_b = B_W'(bx_reg);
            end
            S_R1:
            begin
                mul_a = sin_a;
                mul_b = B_W'(by_reg);
            end
            S_R2:
            begin
                mul_a = sin_a;
                mul_b = B_W'(bx_reg);
            end
            S_R3:
            begin
                mul_a = cos_a;
                mul_b = B_W'(by_reg);
            end
            S_R4:
            begin
                mul_a = A_W'(vx_reg) + A_W'(pvx_reg);
                mul_b = $signed(B_W'(period_reg));
            end
            S_P0:
            begin
                mul_a = A_W'(vy_reg) + A_W'(pvy_reg);
                mul_b = $signed(B_W'(period_reg));
            end
            S_P1:
            begin
                mul_a = A_W'(w_reg) + A_W'(pw_reg);
                mul_b = $signed(B_W'(period_reg));
            end
            S_H0:
            begin
                mul_a = $signed(A_W'(prod_abs[31:16]));
                mul_b = B_W'(obk_pkg::HEAD_GAIN);
            end
            S_H1:
            begin
                mul_a = $signed(A_W'(hmag_reg[15:0]));
                mul_b = B_W'(obk_pkg::HEAD_GAIN);
            end
            S_I0:
            begin
                mul_a = cos_a;
                mul_b = B_W'(tick_reg.cmd_vel_x);
            end
            S_I1:
            begin
                mul_a = sin_a;
                mul_b = B_W'(tick_reg.cmd_vel_y);
            end
            S_I2:
            begin
                mul_a = cos_a;
                mul_b = B_W'(tick_reg.cmd_vel_y);
            end
            S_I3:
            begin
                mul_a = sin_a;
                mul_b = B_W'(tick_reg.cmd_vel_x);
            end
            S_I4:
            begin
                mul_a = A_W'(tick_reg.cmd_turn_rate);
                mul_b = $signed(B_W'(offset_reg));
            end
            S_I5:
            begin
                mul_a = bxi_reg + byi_reg;
                mul_b = B_W'(obk_pkg::COS45_GAIN);
            end
            S_K1:
            begin
                mul_a = byi_reg - bxi_reg;
                mul_b = B_W'(obk_pkg::COS45_GAIN);
            end
            S_K2:
            begin
                mul_a = -bxi_reg - byi_reg;
                mul_b = B_W'(obk_pkg::COS45_GAIN);
            end
            S_K3:
            begin
                mul_a = bxi_reg - byi_reg;
                mul_b = B_W'(obk_pkg::COS45_GAIN);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (tick_acc)
                    state_next = S_M0;
            S_M0:    state_next = S_M1;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_DIV;
            S_DIV:
                if (!div_busy && !cor_busy)
                    state_next = S_R0;
            S_R0:    state_next = S_R1;
            S_R1:    state_next = S_R2;
            S_R2:    state_next = S_R3;
            S_R3:    state_next = S_R4;
            S_R4:    state_next = S_P0;
            S_P0:    state_next = S_P1;
            S_P1:    state_next = S_H0;
            S_H0:    state_next = S_H1;
            S_H1:    state_next = S_H2;
            S_H2:    state_next = S_COR;
            S_COR:   state_next = S_CWAIT;
            S_CWAIT:
                if (!cor_busy)
                    state_next = S_I0;
            S_I0:    state_next = S_I1;
            S_I1:    state_next = S_I2;
            S_I2:    state_next = S_I3;
            S_I3:    state_next = S_I4;
            S_I4:    state_next = S_I5;
            S_I5:    state_next = S_K1;
            S_K1:    state_next = S_K2;
            S_K2:    state_next = S_K3;
            S_K3:    state_next = S_K4;
            S_K4:    state_next = S_DONE;
            S_DONE:
                if (result_load)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            period_reg       <= obk_pkg::PERIOD_RESET;
            offset_reg       <= obk_pkg::OFFSET_RESET;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            heading_reg      <= '0;
            pvx_reg          <= '0;
            pvy_reg          <= '0;
            pw_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    obk_pkg::CFG_SAMPLE_PERIOD: period_reg <= cfg_data;
                    obk_pkg::CFG_WHEEL_OFFSET:  offset_reg <= cfg_data[obk_pkg::OFS_W-1:0];
                    default:                    period_reg <= period_reg;
                endcase
            end
            if (state_reg == S_P0)
                pos_x_reg <= obk_pkg::sat32(ACC_W'(pos_x_reg) + obk_pkg::rnd_shift(prod_ext, 13));
            if (state_reg == S_P1)
                pos_y_reg <= obk_pkg::sat32(ACC_W'(pos_y_reg) + obk_pkg::rnd_shift(prod_ext, 13));
            if (state_reg == S_H2)
            begin
                if (!tick_reg.hold_heading)
                    heading_reg <= heading_reg + dh;
                pvx_reg <= vx_reg;
                pvy_reg <= vy_reg;
                pw_reg  <= w_reg;
            end
            if (result_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (tick_acc)
            tick_reg <= tick;
        unique case (state_reg)
            S_M1: bx_reg <= obk_pkg::sat16(obk_pkg::rnd_shift(prod_ext, 16));
            S_M2: by_reg <= obk_pkg::sat16(obk_pkg::rnd_shift(prod_ext, 16));
            S_M3: wneg_reg <= prod_reg[P_W-1];
            S_DIV: w_reg <= obk_pkg::sat16(ACC_W'(w_signed));
            S_R1: acc_reg <= prod_ext;
            S_R2: vx_reg <= obk_pkg::sat16(obk_pkg::rnd_shift(acc_reg - prod_ext, 15));
            S_R3: acc_reg <= prod_ext;
            S_R4: vy_reg <= obk_pkg::sat16(obk_pkg::rnd_shift(acc_reg + prod_ext, 15));
            S_H0:
            begin
                hneg_reg <= prod_reg[P_W-1];
                hmag_reg <= prod_abs[obk_pkg::POS_W-1:0];
            end
            S_H1: hacc_reg <= {prod_reg[41:0], 16'd0};
            S_I1: acc_reg <= prod_ext;
            S_I2: bxi_reg <= A_W'(obk_pkg::rnd_shift(acc_reg + prod_ext, 15));
            S_I3: acc_reg <= prod_ext;
            S_I4: byi_reg <= A_W'(obk_pkg::rnd_shift(acc_reg - prod_ext, 15));
            S_I5: td_reg <= A_W'(obk_pkg::rnd_shift(prod_ext, 12));
            S_K1: set_reg[0] <= obk_pkg::sat16(obk_pkg::rnd_shift(prod_ext, 15) + td_ext);
            S_K2: set_reg[1] <= obk_pkg::sat16(obk_pkg::rnd_shift(prod_ext, 15) + td_ext);
            S_K3: set_reg[2] <= obk_pkg::sat16(obk_pkg::rnd_shift(prod_ext, 15) + td_ext);
            S_K4: set_reg[3] <= obk_pkg::sat16(obk_pkg::rnd_shift(prod_ext, 15) + td_ext);
            default: acc_reg <= acc_reg;
        endcase
        if (result_load)
        begin
            result_reg.pos_x           <= pos_x_reg;
            result_reg.pos_y           <= pos_y_reg;
            result_reg.heading         <= heading_reg;
            result_reg.wheel_set_one   <= set_reg[0];
            result_reg.wheel_set_two   <= set_reg[1];
            result_reg.wheel_set_three <= set_reg[2];
            result_reg.wheel_set_four  <= set_reg[3];
        end
    end

    `OBK_ASSERT_NEVER(a_cor_restart, cor_start && cor_busy, "CORDIC restarted while busy")
    `OBK_ASSERT_NEVER(a_div_restart, div_start && div_busy, "divider restarted while busy")
    `OBK_ASSERT(a_hdg_only_h2, (state_reg != S_H2) |=> $stable(heading_reg), "heading moved")
    `OBK_ASSERT(a_done_hold, (result_valid_reg && result_stall && state_reg == S_DONE) |=> (state_reg == S_DONE), "result overwritten")

endmodule
